/* hdl/rpa_pkg.sv */
package rpa_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int DATA_W         = 32;
   localparam int REQ_DATA_W     = 7 * DATA_W;
   localparam int RSP_DATA_W     = 3 * DATA_W;
   localparam logic [31:0] SPEED_RESET = 32'd65536;
   localparam logic [31:0] RANGE_RESET = 32'd6553600;

   localparam logic [1:0] REQ_SPAWN = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic CSR_SPEED = 1'b0;
   localparam logic CSR_RANGE = 1'b1;

   localparam logic [4:0] ROOT_LAST = 5'd31;
   localparam logic [4:0] DIV_LAST  = 5'd30;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_NORM, ST_SQ_MUL, ST_SQ_ACC, ST_ROOT, ST_DIV_INIT,
      ST_DIV, ST_DIV_STORE, ST_START, ST_T_MUL, ST_T_ADV, ST_P_MUL, ST_P_ADD,
      ST_T_END, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_NORM, CMD_MUL, CMD_ACC, CMD_ROOT, CMD_DIV_INIT,
      CMD_DIV_STEP, CMD_DIV_STORE, CMD_START, CMD_ADVANCE, CMD_POS, CMD_ARRIVE
   } cmd_op_type;

   typedef enum logic [1:0] {MUL_SQ, MUL_STEP, MUL_POS} mul_sel_type;

   typedef struct packed {
      cmd_op_type  op;
      mul_sel_type sel;
      logic [1:0]  axis;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       spawn_ok;
      logic       norm_done;
      logic       tick_go;
   } status_type;

endpackage

/* hdl/rpa_ctrl.sv */
module rpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rpa_pkg::status_type status,
   output rpa_pkg::cmd_type    cmd
);
   import rpa_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 2'd0;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            axis_in = 2'd0;
            cnt_in  = 5'd0;
            case (status.kind)
               REQ_SPAWN: state_in = status.spawn_ok ? ST_NORM : ST_RESP;
               REQ_TICK:  state_in = status.tick_go ? ST_T_MUL : ST_RESP;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: state_in = ST_SQ_ACC;
         ST_SQ_ACC: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_ROOT;
               axis_in  = 2'd0;
            end else begin
               state_in = ST_SQ_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = ST_DIV_INIT;
               cnt_in   = 5'd0;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIV_STORE;
               cnt_in   = 5'd0;
            end
         end
         ST_DIV_STORE: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_START;
            end else begin
               state_in = ST_DIV_INIT;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_START: state_in = ST_RESP;
         ST_T_MUL: state_in = ST_T_ADV;
         ST_T_ADV: state_in = ST_P_MUL;
         ST_P_MUL: state_in = ST_P_ADD;
         ST_P_ADD: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_T_END;
            end else begin
               state_in = ST_P_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_T_END: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd.op     = CMD_NONE;
      cmd.sel    = MUL_SQ;
      cmd.axis   = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = CMD_LOAD;
         end
         ST_NORM:      if (!status.norm_done) cmd.op = CMD_NORM;
         ST_SQ_MUL:    cmd.op = CMD_MUL;
         ST_SQ_ACC:    cmd.op = CMD_ACC;
         ST_ROOT:      cmd.op = CMD_ROOT;
         ST_DIV_INIT:  cmd.op = CMD_DIV_INIT;
         ST_DIV:       cmd.op = CMD_DIV_STEP;
         ST_DIV_STORE: cmd.op = CMD_DIV_STORE;
         ST_START:     cmd.op = CMD_START;
         ST_T_MUL: begin
            cmd.op  = CMD_MUL;
            cmd.sel = MUL_STEP;
         end
         ST_T_ADV:     cmd.op = CMD_ADVANCE;
         ST_P_MUL: begin
            cmd.op  = CMD_MUL;
            cmd.sel = MUL_POS;
         end
         ST_P_ADD:     cmd.op = CMD_POS;
         ST_T_END:     cmd.op = CMD_ARRIVE;
         ST_RESP:      rsp_tvalid = 1'b1;
         default:      cmd.op = CMD_NONE;
      endcase
   end

endmodule

/* hdl/rpa_dp.sv */
module rpa_dp #(
   parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rpa_pkg::cmd_type                cmd,
   output rpa_pkg::status_type             status,
   input  logic [rpa_pkg::REQ_DATA_W-1:0]  req_data,
   input  logic [1:0]                      req_kind,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_data,
   output logic [rpa_pkg::RSP_DATA_W-1:0]  pos_data,
   output logic                            flag,
   output logic                            active
);
   import rpa_pkg::*;

   localparam int SAT_W = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;
   localparam logic [31:0] NORM_LIMIT = 32'h4000_0000;

   function automatic logic signed [31:0] sat_c(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[31:0];
   endfunction

   logic [31:0] speed_ff, range_ff;
   logic signed [31:0] org_ff [3];
   logic [31:0] mag_ff [3];
   logic        neg_ff [3];
   logic [31:0] step_ff;
   logic [1:0]  kind_ff;
   logic signed [31:0] start_ff [3];
   logic signed [31:0] unit_ff [3];
   logic signed [31:0] cur_ff [3];
   logic [31:0] dist_ff;
   logic        moving_ff, flag_ff;
   logic [63:0] prod_ff, acc_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [30:0] quot_ff;
   logic        dbit_ff;

   logic [31:0] mul_a, mul_b, u_raw, unit_abs;
   logic [63:0] mul_p;
   logic [34:0] rem_sh, trial;
   logic        root_ge;
   logic [33:0] dv_t;
   logic        dv_ge;
   logic [47:0] requested;
   logic [31:0] remaining, adv;
   logic signed [33:0] base, off, pos_sum;

   assign u_raw    = unit_ff[cmd.axis];
   assign unit_abs = u_raw[31] ? (~u_raw + 32'd1) : u_raw;

   always_comb begin
      case (cmd.sel)
         MUL_SQ: begin
            mul_a = mag_ff[cmd.axis];
            mul_b = mag_ff[cmd.axis];
         end
         MUL_STEP: begin
            mul_a = speed_ff;
            mul_b = step_ff;
         end
         MUL_POS: begin
            mul_a = unit_abs;
            mul_b = dist_ff;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // one root digit per step, two radicand bits brought in
   assign rem_sh  = {rem_ff[32:0], acc_ff[63:62]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ge = rem_sh >= trial;

   // one quotient bit per step
   assign dv_t  = {rem_ff[32:0], dbit_ff};
   assign dv_ge = dv_t >= {2'b00, root_ff};

   assign requested = prod_ff[63:16];
   assign remaining = (range_ff > dist_ff) ? (range_ff - dist_ff) : 32'd0;
   assign adv = (requested < {16'd0, remaining}) ? requested[31:0] : remaining;

   assign base    = 34'(start_ff[cmd.axis]);
   assign off     = {1'b0, prod_ff[62:30]};
   assign pos_sum = u_raw[31] ? (base - off) : (base + off);

   assign status.kind      = kind_ff;
   assign status.spawn_ok  = ((mag_ff[0] | mag_ff[1] | mag_ff[2]) != 32'd0)
                             && (speed_ff != 32'd0) && (range_ff != 32'd0);
   assign status.norm_done = (mag_ff[0] > NORM_LIMIT) || (mag_ff[1] > NORM_LIMIT)
                             || (mag_ff[2] > NORM_LIMIT);
   assign status.tick_go   = moving_ff && (step_ff != 32'd0);

   assign pos_data = {cur_ff[2], cur_ff[1], cur_ff[0]};
   assign flag     = flag_ff;
   assign active   = moving_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_RESET;
         range_ff  <= RANGE_RESET;
         dist_ff   <= 32'd0;
         moving_ff <= 1'b0;
         flag_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            unit_ff[i]  <= '0;
            cur_ff[i]   <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SPEED: speed_ff <= csr_data;
               CSR_RANGE: range_ff <= csr_data;
               default:   speed_ff <= speed_ff;
            endcase
         end
         case (cmd.op)
            CMD_LOAD: begin
               for (int i = 0; i < 3; i++) begin
                  org_ff[i] <= req_data[i*32 +: 32];
                  mag_ff[i] <= req_data[96 + i*32 + 31]
                               ? (~req_data[96 + i*32 +: 32] + 32'd1)
                               : req_data[96 + i*32 +: 32];
                  neg_ff[i] <= req_data[96 + i*32 + 31];
               end
               step_ff <= req_data[192 +: 32];
               kind_ff <= req_kind;
               flag_ff <= 1'b0;
               acc_ff  <= 64'd0;
               rem_ff  <= 35'd0;
               root_ff <= 32'd0;
               if (req_kind == REQ_SPAWN || req_kind == REQ_CLEAR) begin
                  dist_ff   <= 32'd0;
                  moving_ff <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     start_ff[i] <= '0;
                     unit_ff[i]  <= '0;
                     cur_ff[i]   <= '0;
                  end
               end
            end
            CMD_NORM: begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= {mag_ff[i][30:0], 1'b0};
            end
            CMD_MUL: prod_ff <= mul_p;
            CMD_ACC: acc_ff <= acc_ff + prod_ff;
            CMD_ROOT: begin
               acc_ff <= {acc_ff[61:0], 2'b00};
               if (root_ge) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
            end
            CMD_DIV_INIT: begin
               rem_ff  <= {4'd0, mag_ff[cmd.axis][31:1]};
               dbit_ff <= mag_ff[cmd.axis][0];
               quot_ff <= 31'd0;
            end
            CMD_DIV_STEP: begin
               dbit_ff <= 1'b0;
               quot_ff <= {quot_ff[29:0], dv_ge};
               if (dv_ge) rem_ff <= {1'b0, dv_t - {2'b00, root_ff}};
               else       rem_ff <= {1'b0, dv_t};
            end
            CMD_DIV_STORE: begin
               unit_ff[cmd.axis] <= neg_ff[cmd.axis] ? -$signed({1'b0, quot_ff})
                                                     : $signed({1'b0, quot_ff});
            end
            CMD_START: begin
               for (int i = 0; i < 3; i++) begin
                  start_ff[i] <= sat_c(34'(org_ff[i]));
                  cur_ff[i]   <= sat_c(34'(org_ff[i]));
               end
               moving_ff <= 1'b1;
               flag_ff   <= 1'b1;
            end
            CMD_ADVANCE: dist_ff <= dist_ff + adv;
            CMD_POS: cur_ff[cmd.axis] <= sat_c(pos_sum);
            CMD_ARRIVE: begin
               if (dist_ff >= range_ff) begin
                  moving_ff <= 1'b0;
                  flag_ff   <= 1'b1;
               end
            end
            default: flag_ff <= flag_ff;
         endcase
      end
   end

endmodule

/* hdl/ray_point_advance_clamped_unit.sv */
// Steps: a spawn normalizes the aim, squares and sums it, takes the root and
//    runs three divisions; a tick forms four products on one multiplier; clear
//    and rejected items go straight from dispatch to the response.
// Throughput: one item at a time; the next is taken the cycle after the response beat.
// Reset: synchronous, active high; restores speed 1.0 and range 100.0 and
//    clears the motion state.
module ray_point_advance_clamped_unit #(
   parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // origin_x, origin_y, origin_z, aim_x, aim_y, aim_z, step_time
   input  logic [rpa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pos_x, pos_y, pos_z
   output logic [rpa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // flag, is_active
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_data
);
   import rpa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       flag, active;

   // registers take a write on any cycle; the user writes them only while idle, unenforced
   assign csr_ready = 1'b1;
   assign rsp_tuser = {active, flag};

   // sequencer: accepts a beat, walks the datapath, holds the response
   rpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, shared multiplier, root and divide steps; the position registers
   // drive the response beat directly and hold while it waits
   rpa_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_tdata),
      .req_kind  (req_tuser),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pos_data  (rsp_tdata),
      .flag      (flag),
      .active    (active)
   );

endmodule

/* hdl/rpa_checker.sv */
module rpa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // a held response keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   // one item in flight: never ready while a response is shown
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while response pending");

   // an accepted beat makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken before response");

   // reset leaves the block idle and empty
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind ray_point_advance_clamped_unit rpa_checker u_rpa_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import rpa_pkg::*;

   localparam int IDLE_LIMIT = 6000;   // longest quiet stretch: hold-off plus a spawn
   localparam int HOLD_CYCLES = 400;
   localparam int END_CYCLES = 200;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] org [3];
      logic signed [31:0] aim [3];
      logic [31:0]        step;
   } point_req_type;

   typedef struct {
      logic               flag;
      logic signed [31:0] pos [3];
      logic               active;
   } point_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = REQ_SPAWN;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_SPEED;
   logic [31:0] csr_data = '0;

   ray_point_advance_clamped_unit dut (.*);

   // Mirror of the block's motion state and registers
   logic [31:0]        cfg_speed, cfg_range;
   logic signed [31:0] ray_start [3];
   logic signed [31:0] ray_dir [3];
   logic signed [31:0] ray_pos [3];
   logic [31:0]        travelled;
   logic               travelling;

   point_rsp_type expected_beats [$];
   int         mismatches = 0;
   int         burst_left = 0;
   logic       hold_off = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_ray();
      for (int i = 0; i < 3; i++) begin
         ray_start[i] = 0;
         ray_dir[i] = 0;
         ray_pos[i] = 0;
      end
      travelled = 0;
      travelling = 1'b0;
   endfunction

   // Floor square root, one result bit per pass from the top
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (t * t <= v) res = t;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic spawn_ray(point_req_type r);
      logic [63:0] mag [3];
      logic [63:0] m, sum, root, u;
      int k;
      clear_ray();
      for (int i = 0; i < 3; i++)
         mag[i] = r.aim[i] < 0 ? 64'(-64'(r.aim[i])) : 64'(r.aim[i]);
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      if (m == 0 || cfg_speed == 0 || cfg_range == 0) return 1'b0;
      // normalize so the largest aim sits just at or below 2^31
      k = 0;
      while ((m << 1) <= 64'h8000_0000) begin
         m = m << 1;
         k++;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] << k;
         sum += mag[i] * mag[i];
      end
      root = floor_root(sum);
      if (root == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         u = (mag[i] << 30) / root;
         ray_dir[i] = r.aim[i] < 0 ? -u[31:0] : u[31:0];
         ray_start[i] = r.org[i];
         ray_pos[i] = r.org[i];
      end
      travelling = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic tick_ray(logic [31:0] step);
      logic [63:0] want, left, adv, mag, off;
      if (!travelling || step == 0) return 1'b0;
      left = cfg_range > travelled ? 64'(cfg_range - travelled) : 64'd0;
      want = (64'(cfg_speed) * 64'(step)) >> 16;
      adv = want < left ? want : left;
      travelled = travelled + adv[31:0];
      for (int i = 0; i < 3; i++) begin
         mag = ray_dir[i] < 0 ? 64'(-64'(ray_dir[i])) : 64'(ray_dir[i]);
         off = (mag * 64'(travelled)) >> 30;
         ray_pos[i] = clamp32(64'(ray_start[i]) + (ray_dir[i] < 0 ? -$signed(off) : $signed(off)));
      end
      if (travelled >= cfg_range) begin
         travelling = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic point_rsp_type predict_point(point_req_type r);
      point_rsp_type b;
      b.flag = 1'b0;
      case (r.kind)
         REQ_SPAWN: b.flag = spawn_ray(r);
         REQ_TICK:  b.flag = tick_ray(r.step);
         REQ_CLEAR: clear_ray();
         default: ;  // undefined kind leaves everything alone
      endcase
      for (int i = 0; i < 3; i++) b.pos[i] = ray_pos[i];
      b.active = travelling;
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Send one beat; bursts of random length with random gaps between them
   task automatic send_item(point_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {r.step, r.aim[2], r.aim[1], r.aim[0], r.org[2], r.org[1], r.org[0]};
      do @(posedge clock); while (!req_tready);
      expected_beats.push_back(predict_point(r));
   endtask

   // Drop valid and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SPEED) cfg_speed = value;
      else cfg_range = value;
   endtask

   function automatic point_req_type spawn_req(logic signed [31:0] ox, oy, oz, ax, ay, az);
      point_req_type r;
      r.kind = REQ_SPAWN;
      r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
      r.aim[0] = ax; r.aim[1] = ay; r.aim[2] = az;
      r.step = $urandom;  // ignored by spawn; toggle it anyway
      return r;
   endfunction

   function automatic point_req_type other_req(logic [1:0] kind, logic [31:0] step);
      point_req_type r;
      r.kind = kind;
      for (int i = 0; i < 3; i++) begin
         r.org[i] = $urandom;
         r.aim[i] = $urandom;
      end
      r.step = step;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_origin();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_aim();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return $urandom_range(0, 15) - 8;
         2: return 32'sh8000_0000;
         3: return 32'sh7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_step();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom_range(1, 4);
         2: return $urandom;
         default: return $urandom_range(1, 32'h0004_0000);
      endcase
   endfunction

   // Extremes of origin and aim, every request kind, each special case
   task automatic test_directed();
      send_item(other_req(REQ_TICK, 32'h0001_0000));   // tick while idle
      send_item(spawn_req(0, 0, 0, 0, 0, 0));           // zero aim rejected
      send_item(spawn_req(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'h0001_0000, 0, 0));
      send_item(other_req(REQ_TICK, 0));                // zero step ignored
      send_item(other_req(REQ_TICK, 32'h0002_0000));
      send_item(spawn_req(32'sh8000_0000, 32'sh7FFF_FFFF, 5, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh8000_0000));
      send_item(other_req(REQ_TICK, 32'hFFFF_FFFF));    // saturate at range, arrive
      send_item(other_req(REQ_TICK, 32'h0001_0000));    // already arrived
      send_item(spawn_req(100, -100, 7, -3, 4, 32'sh7FFF_FFFF));
      send_item(other_req(2'd3, 32'h0001_0000));        // undefined kind
      send_item(other_req(REQ_CLEAR, $urandom));
      send_item(other_req(REQ_TICK, 32'h0001_0000));    // cleared, no motion
      // tiny step truncates to zero distance but still ticks
      write_csr(CSR_SPEED, 32'd1);
      send_item(spawn_req(1, 2, 3, 1, 1, 1));
      send_item(other_req(REQ_TICK, 32'd1));
      write_csr(CSR_SPEED, SPEED_RESET);
      send_item(other_req(REQ_TICK, 32'h0003_0000));
      // lower the range below the travelled distance: next tick arrives in place
      write_csr(CSR_RANGE, 32'h0001_0000);
      send_item(other_req(REQ_TICK, 32'd1));
      // zero speed and zero range both reject a spawn
      write_csr(CSR_SPEED, 32'd0);
      send_item(spawn_req(1, 1, 1, 1, 0, 0));
      write_csr(CSR_SPEED, 32'hFFFF_FFFF);
      write_csr(CSR_RANGE, 32'd0);
      send_item(spawn_req(1, 1, 1, 1, 0, 0));
      write_csr(CSR_RANGE, 32'hFFFF_FFFF);
      send_item(spawn_req(32'sh7FFF_0000, 0, 32'sh8001_0000, 5, 0, -5));
      send_item(other_req(REQ_TICK, 32'hFFFF_FFFF));    // position saturates
      send_item(other_req(REQ_TICK, 32'hFFFF_FFFF));
   endtask

   // Mostly spawn followed by ticks; clears, rejects and junk kinds as noise
   task automatic test_random(int total);
      logic [31:0] speeds [4] = '{SPEED_RESET, 32'd1, 32'hFFFF_FFFF, 32'h0000_4000};
      logic [31:0] ranges [4] = '{RANGE_RESET, 32'hFFFF_FFFF, 32'd1, 32'h0010_0000};
      int sent, phase, ticks;
      sent = 0;
      phase = 0;
      while (sent < total) begin
         if (sent >= phase * 100) begin
            write_csr(CSR_SPEED, phase % 3 == 2 ? $urandom : speeds[phase % 4]);
            write_csr(CSR_RANGE, phase % 4 == 3 ? $urandom : ranges[(phase / 2) % 4]);
            phase++;
         end
         case ($urandom_range(0, 9))
            7: begin
               send_item(other_req(REQ_CLEAR, $urandom));
               sent++;
            end
            8: begin
               send_item(other_req(2'd3, rand_step()));
               sent++;
            end
            9: begin
               send_item(other_req(REQ_TICK, rand_step()));
               sent++;
            end
            default: begin
               send_item(spawn_req(rand_origin(), rand_origin(), rand_origin(),
                                   rand_aim(), rand_aim(), rand_aim()));
               ticks = $urandom_range(1, 8);
               repeat (ticks) send_item(other_req(REQ_TICK, rand_step()));
               sent += ticks + 1;
            end
         endcase
      end
   endtask

   // Hold the response side off while items keep coming
   task automatic test_backpressure();
      drain();
      hold_off <= 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      send_item(spawn_req(rand_origin(), 0, rand_origin(), 32'h0001_0000, -7, 3));
      repeat (5) send_item(other_req(REQ_TICK, rand_step()));
   endtask

   // Response side: random stall pattern; always ready, mostly ready or mostly stalled
   int rx_cycle = 0;
   int rx_mode = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_off) rsp_tready <= 1'b0;
      else if (rx_mode == 0) rsp_tready <= 1'b1;
      else if (rx_mode == 1) rsp_tready <= $urandom_range(0, 3) != 0;
      else rsp_tready <= $urandom_range(0, 3) == 0;
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin : check_rsp
      point_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[31:0], 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tuser[0] !== want.flag) report_mismatch("flag", rsp_tuser[0], want.flag);
            if (rsp_tuser[1] !== want.active)
               report_mismatch("is_active", rsp_tuser[1], want.active);
            for (int i = 0; i < 3; i++)
               if (rsp_tdata[32*i +: 32] !== want.pos[i])
                  report_mismatch($sformatf("pos[%0d]", i), rsp_tdata[32*i +: 32], want.pos[i]);
         end
      end
   end

   // Watchdog on cycles with no beat on any channel
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      cfg_speed = SPEED_RESET;
      cfg_range = RANGE_RESET;
      clear_ray();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(700);
      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/rpa_pkg.sv
hdl/rpa_ctrl.sv
hdl/rpa_dp.sv
hdl/ray_point_advance_clamped_unit.sv
hdl/rpa_checker.sv
dv/testbench.sv
